>>> rtl/core/ifre_pkg.sv
// Shared constants, types and helper functions for the IIR frequency response core.
// No dependencies; the other files in rtl/core that use it refer to this package by scoped names.
package ifre_pkg;

	localparam int STEPS = 30;

	localparam logic [15:0] HALF_FREQ    = 16'd32768;
	localparam logic [15:0] QUARTER_FREQ = 16'd16384;

	localparam logic [30:0]        HALF_PI_Q30       = 31'd1686629713;
	localparam logic signed [33:0] CORDIC_GAIN_Q30   = 34'sd652032874;
	localparam logic signed [31:0] ONE_Q28           = 32'sd268435456;
	localparam logic signed [30:0] DB_PER_OCTAVE_Q28 = 31'sd808071242;

	localparam logic signed [31:0] SAT_MAX = 32'sh7FFFFFFF;
	localparam logic signed [31:0] SAT_MIN = 32'sh80000000;

	// unit latencies in cycles
	localparam int LAT_SC  = STEPS + 2;
	localparam int LAT_HO  = 5;
	localparam int LAT_XP  = 2;
	localparam int LAT_SQ  = 32;
	localparam int LAT_DIV = 35;
	localparam int LAT_AT  = STEPS + 5;
	localparam int LAT_LG  = 18;
	localparam int LAT_DB  = 2;

	// age of a word at each hand-off point
	localparam int AGE_X   = LAT_SC + LAT_HO + LAT_XP;
	localparam int AGE_DIV = AGE_X + LAT_SQ;
	localparam int AGE_END = AGE_DIV + LAT_DIV;
	localparam int AGE_AT  = AGE_X + LAT_AT;
	localparam int AGE_DB  = AGE_X + LAT_LG + LAT_DB;

	localparam int DLY_XD   = AGE_DIV - AGE_X;
	localparam int DLY_FLAG = AGE_END - AGE_X;
	localparam int DLY_PH   = AGE_END - AGE_AT;
	localparam int DLY_DB   = AGE_END - AGE_DB;

	typedef enum logic [2:0] {
		REG_NUM_COEF_0 = 3'd0,
		REG_NUM_COEF_1 = 3'd1,
		REG_NUM_COEF_2 = 3'd2,
		REG_DEN_COEF_1 = 3'd3,
		REG_DEN_COEF_2 = 3'd4,
		REG_NUM_ORDER  = 3'd5,
		REG_DEN_ORDER  = 3'd6
	} cfg_reg_t;

	typedef enum logic [1:0] {
		MODE_RECT     = 2'd0,
		MODE_POLAR    = 2'd1,
		MODE_DB       = 2'd2,
		MODE_RECT_ALT = 2'd3
	} mode_t;

	function automatic logic [31:0] atan_q30(input logic [4:0] i);
		logic [31:0] a;
		unique case (i)
			5'd0:  a = 32'h3243F6A8;
			5'd1:  a = 32'h1DAC6705;
			5'd2:  a = 32'h0FADBAFC;
			5'd3:  a = 32'h07F56EA6;
			5'd4:  a = 32'h03FEAB76;
			5'd5:  a = 32'h01FFD55B;
			5'd6:  a = 32'h00FFFAAA;
			5'd7:  a = 32'h007FFF55;
			5'd8:  a = 32'h003FFFEA;
			5'd9:  a = 32'h001FFFFD;
			5'd10: a = 32'h000FFFFF;
			5'd11: a = 32'h0007FFFF;
			5'd12: a = 32'h0003FFFF;
			5'd13: a = 32'h0001FFFF;
			5'd14: a = 32'h0000FFFF;
			5'd15: a = 32'h00007FFF;
			5'd16: a = 32'h00003FFF;
			5'd17: a = 32'h00001FFF;
			5'd18: a = 32'h00000FFF;
			5'd19: a = 32'h000007FF;
			5'd20: a = 32'h000003FF;
			5'd21: a = 32'h000001FF;
			5'd22: a = 32'h000000FF;
			5'd23: a = 32'h0000007F;
			5'd24: a = 32'h0000003F;
			5'd25: a = 32'h0000001F;
			5'd26: a = 32'h0000000F;
			5'd27: a = 32'h00000008;
			5'd28: a = 32'h00000004;
			5'd29: a = 32'h00000002;
			default: a = 32'h0;
		endcase
		return a;
	endfunction

	// position of the highest set bit, zero for a zero word
	function automatic logic [5:0] lead_pos(input logic [63:0] v);
		logic [5:0] p;
		p = '0;
		for (int i = 0; i < 64; i++) begin
			if (v[i]) p = 6'(i);
		end
		return p;
	endfunction

endpackage

>>> rtl/core/ifre_sincos.sv
// Frequency clamp and fold, then a rotation CORDIC giving z = exp(-j*2*pi*f) in Q28.
// Depends on ifre_pkg.
module ifre_sincos (
	input  logic               clk,
	input  logic               en,
	input  logic [15:0]        freq,
	output logic signed [31:0] zr,
	output logic signed [31:0] zi
);

	logic [15:0] fc, g;
	logic [46:0] ang_prod;

	logic signed [33:0] x_s [0:ifre_pkg::STEPS];
	logic signed [33:0] y_s [0:ifre_pkg::STEPS];
	logic signed [33:0] z_s [0:ifre_pkg::STEPS];
	logic               flip_s [0:ifre_pkg::STEPS];

	logic signed [33:0] cr, sr;

	always_comb begin
		fc = (freq > ifre_pkg::HALF_FREQ) ? ifre_pkg::HALF_FREQ : freq;
		g  = (fc > ifre_pkg::QUARTER_FREQ) ? (ifre_pkg::HALF_FREQ - fc) : fc;
	end

	assign ang_prod = 47'(g) * 47'(ifre_pkg::HALF_PI_Q30);

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0]    <= ifre_pkg::CORDIC_GAIN_Q30;
			y_s[0]    <= '0;
			z_s[0]    <= $signed({1'b0, ang_prod[46:14]});
			flip_s[0] <= fc > ifre_pkg::QUARTER_FREQ;
		end
	end

	for (genvar k = 0; k < ifre_pkg::STEPS; k++) begin : g_rot
		always_ff @(posedge clk) begin
			if (en) begin
				if (!z_s[k][33]) begin
					x_s[k+1] <= x_s[k] - (y_s[k] >>> k);
					y_s[k+1] <= y_s[k] + (x_s[k] >>> k);
					z_s[k+1] <= z_s[k] - $signed({2'b00, ifre_pkg::atan_q30(5'(k))});
				end else begin
					x_s[k+1] <= x_s[k] + (y_s[k] >>> k);
					y_s[k+1] <= y_s[k] - (x_s[k] >>> k);
					z_s[k+1] <= z_s[k] + $signed({2'b00, ifre_pkg::atan_q30(5'(k))});
				end
				flip_s[k+1] <= flip_s[k];
			end
		end
	end

	// Q30 -> Q28 with rounding; upper half band mirrors cos
	assign cr = (x_s[ifre_pkg::STEPS] + 34'sd2) >>> 2;
	assign sr = (y_s[ifre_pkg::STEPS] + 34'sd2) >>> 2;

	always_ff @(posedge clk) begin
		if (en) begin
			zr <= flip_s[ifre_pkg::STEPS] ? 32'(-cr) : 32'(cr);
			zi <= 32'(-sr);
		end
	end

endmodule

>>> rtl/core/ifre_horner.sv
// Complex Horner evaluation of one order-two polynomial at z, result rounded to Q24.
// Depends on ifre_pkg for nothing but style; five register stages.
module ifre_horner (
	input  logic               clk,
	input  logic               en,
	input  logic signed [31:0] zr,
	input  logic signed [31:0] zi,
	input  logic signed [31:0] c0,
	input  logic signed [31:0] c1,
	input  logic signed [31:0] c2,
	input  logic [1:0]         ord,
	output logic signed [31:0] re,
	output logic signed [31:0] im
);

	localparam logic signed [63:0] RND28_64 = 64'sd134217728;
	localparam logic signed [67:0] RND28_68 = 68'sd134217728;

	logic [1:0]         ordc;
	logic signed [31:0] t0;

	logic signed [63:0] p1r, p1i;
	logic signed [63:0] p1r_s1, p1i_s1;
	logic signed [31:0] zr_s1, zi_s1;
	logic               ord2_s1;

	logic signed [63:0] a1r_full, a1i_full;
	logic signed [35:0] tr_s2, ti_s2, a1r_s2, a1i_s2;
	logic signed [31:0] zr_s2, zi_s2;
	logic               ord2_s2;

	logic signed [67:0] prr, pii, pri, pir;
	logic signed [67:0] prr_s3, pii_s3, pri_s3, pir_s3;
	logic signed [35:0] a1r_s3, a1i_s3;
	logic               ord2_s3;

	logic signed [67:0] a2r_full, a2i_full;
	logic signed [39:0] ar, ai;
	logic signed [39:0] re_s4, im_s4;
	logic signed [39:0] re_r, im_r;

	always_comb begin
		ordc = (ord > 2'd2) ? 2'd2 : ord;
		unique case (ordc)
			2'd2:    t0 = c2;
			2'd1:    t0 = c1;
			default: t0 = '0;
		endcase
	end

	assign p1r = t0 * zr;
	assign p1i = t0 * zi;

	always_ff @(posedge clk) begin
		if (en) begin
			p1r_s1  <= p1r;
			p1i_s1  <= p1i;
			zr_s1   <= zr;
			zi_s1   <= zi;
			ord2_s1 <= ordc == 2'd2;
		end
	end

	assign a1r_full = (p1r_s1 + RND28_64) >>> 28;
	assign a1i_full = (p1i_s1 + RND28_64) >>> 28;

	always_ff @(posedge clk) begin
		if (en) begin
			tr_s2   <= 36'(a1r_full) + 36'(c1);
			ti_s2   <= 36'(a1i_full);
			a1r_s2  <= 36'(a1r_full);
			a1i_s2  <= 36'(a1i_full);
			zr_s2   <= zr_s1;
			zi_s2   <= zi_s1;
			ord2_s2 <= ord2_s1;
		end
	end

	assign prr = tr_s2 * zr_s2;
	assign pii = ti_s2 * zi_s2;
	assign pri = tr_s2 * zi_s2;
	assign pir = ti_s2 * zr_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			prr_s3  <= prr;
			pii_s3  <= pii;
			pri_s3  <= pri;
			pir_s3  <= pir;
			a1r_s3  <= a1r_s2;
			a1i_s3  <= a1i_s2;
			ord2_s3 <= ord2_s2;
		end
	end

	assign a2r_full = (prr_s3 - pii_s3 + RND28_68) >>> 28;
	assign a2i_full = (pri_s3 + pir_s3 + RND28_68) >>> 28;
	assign ar = ord2_s3 ? 40'(a2r_full) : 40'(a1r_s3);
	assign ai = ord2_s3 ? 40'(a2i_full) : 40'(a1i_s3);

	always_ff @(posedge clk) begin
		if (en) begin
			re_s4 <= ar + 40'(c0);
			im_s4 <= ai;
		end
	end

	// Q28 -> Q24, round half up
	assign re_r = (re_s4 + 40'sd8) >>> 4;
	assign im_r = (im_s4 + 40'sd8) >>> 4;

	always_ff @(posedge clk) begin
		if (en) begin
			re <= 32'(re_r);
			im <= 32'(im_r);
		end
	end

endmodule

>>> rtl/core/ifre_isqrt.sv
// Pipelined integer square root (floor), one result bit resolved per stage.
// Depends on ifre_pkg for nothing; 32 register stages.
module ifre_isqrt (
	input  logic        clk,
	input  logic        en,
	input  logic [63:0] v,
	output logic [31:0] root
);

	logic [63:0] v_s [0:32];
	logic [63:0] r_s [0:32];

	assign v_s[0] = v;
	assign r_s[0] = '0;

	for (genvar k = 0; k < 32; k++) begin : g_step
		localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
		logic [63:0] rb;
		assign rb = r_s[k] + BIT;
		always_ff @(posedge clk) begin
			if (en) begin
				if (v_s[k] >= rb) begin
					v_s[k+1] <= v_s[k] - rb;
					r_s[k+1] <= (r_s[k] >> 1) + BIT;
				end else begin
					v_s[k+1] <= v_s[k];
					r_s[k+1] <= r_s[k] >> 1;
				end
			end
		end
	end

	assign root = r_s[32][31:0];

endmodule

>>> rtl/core/ifre_divider.sv
// Pipelined signed/unsigned restoring divider giving a saturated Q16.16 quotient.
// Depends on ifre_pkg (saturation limits); 35 register stages.
module ifre_divider (
	input  logic               clk,
	input  logic               en,
	input  logic signed [63:0] n,
	input  logic [63:0]        d,
	output logic signed [31:0] q
);

	logic [63:0] un;
	logic        neg_a;
	logic [63:0] un_a, d_a;

	logic [95:0] rem_s [0:32];
	logic [63:0] d_s   [0:32];
	logic [31:0] q_s   [0:32];
	logic        neg_s [0:32];
	logic        sat_s [0:32];

	logic        over;
	logic [31:0] qq;

	assign un = n[63] ? 64'(-n) : 64'(n);

	always_ff @(posedge clk) begin
		if (en) begin
			neg_a <= n[63];
			un_a  <= un;
			d_a   <= d;
		end
	end

	// integer part too large for the 32 bit quotient register
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= {16'b0, un_a, 16'b0};
			sat_s[0] <= {16'b0, un_a, 16'b0} >= {d_a, 32'b0};
			d_s[0]   <= d_a;
			q_s[0]   <= '0;
			neg_s[0] <= neg_a;
		end
	end

	for (genvar j = 0; j < 32; j++) begin : g_bit
		logic [95:0] sub;
		assign sub = 96'(d_s[j]) << (31 - j);
		always_ff @(posedge clk) begin
			if (en) begin
				if (rem_s[j] >= sub) begin
					rem_s[j+1] <= rem_s[j] - sub;
					q_s[j+1]   <= {q_s[j][30:0], 1'b1};
				end else begin
					rem_s[j+1] <= rem_s[j];
					q_s[j+1]   <= {q_s[j][30:0], 1'b0};
				end
				d_s[j+1]   <= d_s[j];
				neg_s[j+1] <= neg_s[j];
				sat_s[j+1] <= sat_s[j];
			end
		end
	end

	assign qq   = q_s[32];
	assign over = sat_s[32] || (qq >= 32'h80010000) || qq[31];

	always_ff @(posedge clk) begin
		if (en) begin
			if (neg_s[32]) begin
				q <= over ? ifre_pkg::SAT_MIN : -$signed(qq);
			end else begin
				q <= over ? ifre_pkg::SAT_MAX : $signed(qq);
			end
		end
	end

endmodule

>>> rtl/core/ifre_atan2.sv
// Pipelined atan2: normalize, fold to the right half plane, 30 step vectoring CORDIC.
// Depends on ifre_pkg (angle table, leading one search); result Q16 radians.
module ifre_atan2 (
	input  logic               clk,
	input  logic               en,
	input  logic signed [63:0] y,
	input  logic signed [63:0] x,
	output logic signed [31:0] phase
);

	localparam logic signed [33:0] HALF_PI = $signed({3'b000, ifre_pkg::HALF_PI_Q30});

	logic [63:0] ax, ay;

	logic signed [63:0] x_s1, y_s1;
	logic [63:0]        m_s1;

	logic signed [63:0] x_s2, y_s2;
	logic [5:0]         p_s2;
	logic               zero_s2;

	logic signed [43:0] x_s3, y_s3;
	logic               zero_s3;

	logic signed [43:0] x_s [0:ifre_pkg::STEPS];
	logic signed [43:0] y_s [0:ifre_pkg::STEPS];
	logic signed [33:0] z_s [0:ifre_pkg::STEPS];
	logic               zero_s [0:ifre_pkg::STEPS];

	logic signed [33:0] z_rnd;

	assign ax = x[63] ? 64'(-x) : 64'(x);
	assign ay = y[63] ? 64'(-y) : 64'(y);

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1 <= x;
			y_s1 <= y;
			m_s1 <= (ax > ay) ? ax : ay;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s2    <= x_s1;
			y_s2    <= y_s1;
			p_s2    <= ifre_pkg::lead_pos(m_s1);
			zero_s2 <= m_s1 == '0;
		end
	end

	// bring the larger magnitude to [2^39, 2^40)
	always_ff @(posedge clk) begin
		if (en) begin
			if (p_s2 >= 6'd40) begin
				x_s3 <= 44'(x_s2 >>> (p_s2 - 6'd39));
				y_s3 <= 44'(y_s2 >>> (p_s2 - 6'd39));
			end else begin
				x_s3 <= 44'(x_s2 <<< (6'd39 - p_s2));
				y_s3 <= 44'(y_s2 <<< (6'd39 - p_s2));
			end
			zero_s3 <= zero_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (x_s3[43] && !y_s3[43]) begin
				x_s[0] <= y_s3;
				y_s[0] <= -x_s3;
				z_s[0] <= HALF_PI;
			end else if (x_s3[43]) begin
				x_s[0] <= -y_s3;
				y_s[0] <= x_s3;
				z_s[0] <= -HALF_PI;
			end else begin
				x_s[0] <= x_s3;
				y_s[0] <= y_s3;
				z_s[0] <= '0;
			end
			zero_s[0] <= zero_s3;
		end
	end

	for (genvar k = 0; k < ifre_pkg::STEPS; k++) begin : g_vec
		always_ff @(posedge clk) begin
			if (en) begin
				if (!y_s[k][43]) begin
					x_s[k+1] <= x_s[k] + (y_s[k] >>> k);
					y_s[k+1] <= y_s[k] - (x_s[k] >>> k);
					z_s[k+1] <= z_s[k] + $signed({2'b00, ifre_pkg::atan_q30(5'(k))});
				end else begin
					x_s[k+1] <= x_s[k] - (y_s[k] >>> k);
					y_s[k+1] <= y_s[k] + (x_s[k] >>> k);
					z_s[k+1] <= z_s[k] - $signed({2'b00, ifre_pkg::atan_q30(5'(k))});
				end
				zero_s[k+1] <= zero_s[k];
			end
		end
	end

	assign z_rnd = (z_s[ifre_pkg::STEPS] + 34'sd8192) >>> 14;

	always_ff @(posedge clk) begin
		if (en) begin
			phase <= zero_s[ifre_pkg::STEPS] ? '0 : 32'(z_rnd);
		end
	end

endmodule

>>> rtl/core/ifre_log2.sv
// Pipelined log2 in Q16: leading one gives the integer part, 16 squarings the fraction.
// Depends on ifre_pkg (leading one search); 18 register stages.
module ifre_log2 (
	input  logic        clk,
	input  logic        en,
	input  logic [63:0] v,
	output logic [21:0] lg
);

	logic [5:0]  e_s1;
	logic [63:0] v_s1;

	logic [30:0] m_s [0:16];
	logic [21:0] r_s [0:16];

	always_ff @(posedge clk) begin
		if (en) begin
			e_s1 <= ifre_pkg::lead_pos(v);
			v_s1 <= v;
		end
	end

	// mantissa normalized to [2^30, 2^31)
	always_ff @(posedge clk) begin
		if (en) begin
			if (e_s1 >= 6'd30) begin
				m_s[0] <= 31'(v_s1 >> (e_s1 - 6'd30));
			end else begin
				m_s[0] <= 31'(v_s1 << (6'd30 - e_s1));
			end
			r_s[0] <= {e_s1, 16'b0};
		end
	end

	for (genvar j = 0; j < 16; j++) begin : g_sq
		logic [61:0] sq;
		logic [31:0] t;
		assign sq = m_s[j] * m_s[j];
		assign t  = sq[61:30];
		always_ff @(posedge clk) begin
			if (en) begin
				if (t[31]) begin
					m_s[j+1] <= t[31:1];
					r_s[j+1] <= r_s[j] + (22'd1 << (15 - j));
				end else begin
					m_s[j+1] <= t[30:0];
					r_s[j+1] <= r_s[j];
				end
			end
		end
	end

	assign lg = r_s[16];

endmodule

>>> rtl/core/iir_frequency_response_eval_core.sv
// Frequency response evaluator for an order-two rational transfer function B(z)/A(z).
// Depends on ifre_pkg and every ifre_* unit in rtl/core.
//
// One frequency word enters per clock and its result word leaves at the end of the pipeline; the
// pipeline takes a new word every cycle as long as the output side is not stalled. The
// pipeline is made of the 32 stage sine/cosine CORDIC, 5 stage Horner evaluation, two
// cross-product stages, the 32 stage square root and the 35 stage divider, plus the output
// register; the phase (35 stage CORDIC) and dB (18 stage log2 plus scaling) paths run in
// parallel and are delay-matched to the divider. A stall on the output freezes the whole
// pipeline, so nothing is dropped or repeated. Coefficients and orders are plain registers
// and must be written only while the pipeline holds no word.
module iir_frequency_response_eval_core (
	input  logic               clk,
	input  logic               arst_n,

	input  logic               in_valid,
	output logic               in_stall,
	input  logic [15:0]        freq,
	input  logic [1:0]         mode,

	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] first_value,
	output logic signed [31:0] second_value,
	output logic               invalid,

	input  logic               cfg_wr_en,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data
);

	// configuration registers
	logic [31:0] num_coef_0_q, num_coef_1_q, num_coef_2_q;
	logic [31:0] den_coef_1_q, den_coef_2_q;
	logic [1:0]  num_order_q, den_order_q;

	// pipeline control: one enable for every stage
	logic                         en;
	logic [ifre_pkg::AGE_END:0]   vld_q;

	// mode rides along to the divider input and to the output mux
	logic [1:0] mode_dly_q [0:ifre_pkg::AGE_END-1];
	logic [1:0] mode_div, mode_end;

	logic signed [31:0] zr, zi;
	logic signed [31:0] br, bi, ar, ai;

	// cross products
	logic signed [63:0] p_arar_s1, p_aiai_s1, p_brbr_s1, p_bibi_s1;
	logic signed [63:0] p_arbr_s1, p_aibi_s1, p_arbi_s1, p_aibr_s1;
	logic [63:0]        den_s2, pb_s2;
	logic signed [63:0] numr_s2, numi_s2;

	logic [63:0]        den_dly_q  [0:ifre_pkg::DLY_XD-1];
	logic signed [63:0] numr_dly_q [0:ifre_pkg::DLY_XD-1];
	logic signed [63:0] numi_dly_q [0:ifre_pkg::DLY_XD-1];

	logic den_zero_dly_q [0:ifre_pkg::DLY_FLAG-1];
	logic pb_zero_dly_q  [0:ifre_pkg::DLY_FLAG-1];

	logic [31:0]        sq_b, sq_a;
	logic signed [63:0] div1_n;
	logic [63:0]        div1_d;
	logic signed [31:0] div1_q, div2_q;

	logic signed [31:0] phase;
	logic signed [31:0] phase_dly_q [0:ifre_pkg::DLY_PH-1];

	logic [21:0]        lg_b, lg_a;
	logic signed [22:0] lg_diff;
	logic signed [53:0] db_prod;
	logic signed [53:0] db_prod_s1;
	logic signed [53:0] db_rnd;
	logic signed [31:0] db_s2;
	logic signed [31:0] db_dly_q [0:ifre_pkg::DLY_DB-1];

	logic               den_zero_end, pb_zero_end;
	logic signed [31:0] first_nxt, second_nxt;
	logic               invalid_nxt;

	//------------------------------------------------------------------
	// configuration port
	//------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_coef_0_q <= 32'(ifre_pkg::ONE_Q28);
			num_coef_1_q <= '0;
			num_coef_2_q <= '0;
			den_coef_1_q <= '0;
			den_coef_2_q <= '0;
			num_order_q  <= 2'd2;
			den_order_q  <= 2'd2;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				ifre_pkg::REG_NUM_COEF_0: num_coef_0_q <= cfg_data;
				ifre_pkg::REG_NUM_COEF_1: num_coef_1_q <= cfg_data;
				ifre_pkg::REG_NUM_COEF_2: num_coef_2_q <= cfg_data;
				ifre_pkg::REG_DEN_COEF_1: den_coef_1_q <= cfg_data;
				ifre_pkg::REG_DEN_COEF_2: den_coef_2_q <= cfg_data;
				ifre_pkg::REG_NUM_ORDER:  num_order_q  <= cfg_data[1:0];
				ifre_pkg::REG_DEN_ORDER:  den_order_q  <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	//------------------------------------------------------------------
	// flow control: the pipeline moves unless a finished word is held
	//------------------------------------------------------------------
	assign en        = !(vld_q[ifre_pkg::AGE_END] && out_stall);
	assign in_stall  = !en;
	assign out_valid = vld_q[ifre_pkg::AGE_END];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[ifre_pkg::AGE_END-1:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mode_dly_q[0] <= mode;
			for (int k = 1; k < ifre_pkg::AGE_END; k++) mode_dly_q[k] <= mode_dly_q[k-1];
		end
	end

	assign mode_div = mode_dly_q[ifre_pkg::AGE_DIV-1];
	assign mode_end = mode_dly_q[ifre_pkg::AGE_END-1];

	//------------------------------------------------------------------
	// z on the unit circle, then B(z) and A(z)
	//------------------------------------------------------------------
	ifre_sincos u_sincos (
		.clk  (clk),
		.en   (en),
		.freq (freq),
		.zr   (zr),
		.zi   (zi)
	);

	ifre_horner u_horner_num (
		.clk (clk),
		.en  (en),
		.zr  (zr),
		.zi  (zi),
		.c0  ($signed(num_coef_0_q)),
		.c1  ($signed(num_coef_1_q)),
		.c2  ($signed(num_coef_2_q)),
		.ord (num_order_q),
		.re  (br),
		.im  (bi)
	);

	ifre_horner u_horner_den (
		.clk (clk),
		.en  (en),
		.zr  (zr),
		.zi  (zi),
		.c0  (ifre_pkg::ONE_Q28),
		.c1  ($signed(den_coef_1_q)),
		.c2  ($signed(den_coef_2_q)),
		.ord (den_order_q),
		.re  (ar),
		.im  (ai)
	);

	//------------------------------------------------------------------
	// |A|^2, |B|^2 and B*conj(A)
	//------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (en) begin
			p_arar_s1 <= ar * ar;
			p_aiai_s1 <= ai * ai;
			p_brbr_s1 <= br * br;
			p_bibi_s1 <= bi * bi;
			p_arbr_s1 <= ar * br;
			p_aibi_s1 <= ai * bi;
			p_arbi_s1 <= ar * bi;
			p_aibr_s1 <= ai * br;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			den_s2  <= 64'(p_arar_s1 + p_aiai_s1);
			pb_s2   <= 64'(p_brbr_s1 + p_bibi_s1);
			numr_s2 <= p_arbr_s1 + p_aibi_s1;
			numi_s2 <= p_arbi_s1 - p_aibr_s1;
		end
	end

	// rectangular operands wait for the square roots
	always_ff @(posedge clk) begin
		if (en) begin
			den_dly_q[0]  <= den_s2;
			numr_dly_q[0] <= numr_s2;
			numi_dly_q[0] <= numi_s2;
			for (int k = 1; k < ifre_pkg::DLY_XD; k++) begin
				den_dly_q[k]  <= den_dly_q[k-1];
				numr_dly_q[k] <= numr_dly_q[k-1];
				numi_dly_q[k] <= numi_dly_q[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			den_zero_dly_q[0] <= den_s2 == '0;
			pb_zero_dly_q[0]  <= pb_s2 == '0;
			for (int k = 1; k < ifre_pkg::DLY_FLAG; k++) begin
				den_zero_dly_q[k] <= den_zero_dly_q[k-1];
				pb_zero_dly_q[k]  <= pb_zero_dly_q[k-1];
			end
		end
	end

	assign den_zero_end = den_zero_dly_q[ifre_pkg::DLY_FLAG-1];
	assign pb_zero_end  = pb_zero_dly_q[ifre_pkg::DLY_FLAG-1];

	//------------------------------------------------------------------
	// magnitude and rectangular quotients
	//------------------------------------------------------------------
	ifre_isqrt u_isqrt_num (
		.clk  (clk),
		.en   (en),
		.v    (pb_s2),
		.root (sq_b)
	);

	ifre_isqrt u_isqrt_den (
		.clk  (clk),
		.en   (en),
		.v    (den_s2),
		.root (sq_a)
	);

	// divider 1 serves the real part or, in polar mode, the magnitude
	always_comb begin
		if (mode_div == ifre_pkg::MODE_POLAR) begin
			div1_n = $signed({32'b0, sq_b});
			div1_d = {32'b0, sq_a};
		end else begin
			div1_n = numr_dly_q[ifre_pkg::DLY_XD-1];
			div1_d = den_dly_q[ifre_pkg::DLY_XD-1];
		end
	end

	ifre_divider u_div_first (
		.clk (clk),
		.en  (en),
		.n   (div1_n),
		.d   (div1_d),
		.q   (div1_q)
	);

	ifre_divider u_div_second (
		.clk (clk),
		.en  (en),
		.n   (numi_dly_q[ifre_pkg::DLY_XD-1]),
		.d   (den_dly_q[ifre_pkg::DLY_XD-1]),
		.q   (div2_q)
	);

	//------------------------------------------------------------------
	// phase of B*conj(A)
	//------------------------------------------------------------------
	ifre_atan2 u_atan2 (
		.clk   (clk),
		.en    (en),
		.y     (numi_s2),
		.x     (numr_s2),
		.phase (phase)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			phase_dly_q[0] <= phase;
			for (int k = 1; k < ifre_pkg::DLY_PH; k++) phase_dly_q[k] <= phase_dly_q[k-1];
		end
	end

	//------------------------------------------------------------------
	// dB = 10*log10(2) * (log2|B|^2 - log2|A|^2)
	//------------------------------------------------------------------
	ifre_log2 u_log2_num (
		.clk (clk),
		.en  (en),
		.v   (pb_s2),
		.lg  (lg_b)
	);

	ifre_log2 u_log2_den (
		.clk (clk),
		.en  (en),
		.v   (den_s2),
		.lg  (lg_a)
	);

	assign lg_diff = $signed({1'b0, lg_b}) - $signed({1'b0, lg_a});
	assign db_prod = lg_diff * ifre_pkg::DB_PER_OCTAVE_Q28;

	always_ff @(posedge clk) begin
		if (en) begin
			db_prod_s1 <= db_prod;
		end
	end

	// range of the log difference keeps the dB value far inside 32 bits
	assign db_rnd = (db_prod_s1 + 54'sd134217728) >>> 28;

	always_ff @(posedge clk) begin
		if (en) begin
			db_s2 <= 32'(db_rnd);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			db_dly_q[0] <= db_s2;
			for (int k = 1; k < ifre_pkg::DLY_DB; k++) db_dly_q[k] <= db_dly_q[k-1];
		end
	end

	//------------------------------------------------------------------
	// output selection and output register
	//------------------------------------------------------------------
	always_comb begin
		first_nxt   = div1_q;
		second_nxt  = div2_q;
		invalid_nxt = 1'b0;
		priority if (den_zero_end) begin
			first_nxt   = ifre_pkg::SAT_MAX;
			second_nxt  = '0;
			invalid_nxt = 1'b1;
		end else if (mode_end == ifre_pkg::MODE_POLAR) begin
			first_nxt  = div1_q;
			second_nxt = phase_dly_q[ifre_pkg::DLY_PH-1];
		end else if (mode_end == ifre_pkg::MODE_DB) begin
			second_nxt = phase_dly_q[ifre_pkg::DLY_PH-1];
			if (pb_zero_end) begin
				first_nxt   = ifre_pkg::SAT_MIN;
				invalid_nxt = 1'b1;
			end else begin
				first_nxt = db_dly_q[ifre_pkg::DLY_DB-1];
			end
		end else begin
			first_nxt  = div1_q;
			second_nxt = div2_q;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			first_value  <= first_nxt;
			second_value <= second_nxt;
			invalid      <= invalid_nxt;
		end
	end

endmodule
